/* rtl/core/boundary_face_index_codec_top_defines.svh */
// ----------------------------------------------------------------------------
// Boundary face index codec: assertion macros
// Shared concurrent assertion helpers; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_FACE_INDEX_CODEC_TOP_DEFINES_SVH
`define BOUNDARY_FACE_INDEX_CODEC_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define BFIC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BFIC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define BFIC_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define BFIC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

/* rtl/core/bfic_pkg.sv */
// ----------------------------------------------------------------------------
// bfic_pkg
// Types, constants and a face lookup function of the boundary face index codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bfic_pkg;

    localparam int COARSE_BITS     = 8;
    localparam int MAX_SUBDIVISION = 7;
    localparam int ORD_W           = 3;
    localparam int FINE_W          = COARSE_BITS + MAX_SUBDIVISION;
    localparam int SIZE_W          = 2 * FINE_W;
    localparam int LOCAL_W         = SIZE_W;
    localparam int ID_W            = 33;
    localparam int COORD_W         = 15;
    localparam int FACE_W          = 3;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int DIV_STEP        = 3;
    localparam int DIV_STAGES      = (FINE_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_BITS        = DIV_STAGES * DIV_STEP;
    localparam int REM_W           = COARSE_BITS + 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int NUM_FACES_2D    = 4;
    localparam int NUM_FACES_3D    = 6;
    localparam int SETTLE_CYCLES   = 3;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    localparam logic [2:0] REG_THREE_D = 3'd0;
    localparam logic [2:0] REG_COARSE_X = 3'd1;
    localparam logic [2:0] REG_COARSE_Y = 3'd2;
    localparam logic [2:0] REG_COARSE_Z = 3'd3;
    localparam logic [2:0] REG_ORDER = 3'd4;

    typedef logic [1:0] t_axis;
    localparam t_axis AXIS_X = 2'd0;
    localparam t_axis AXIS_Y = 2'd1;
    localparam t_axis AXIS_Z = 2'd2;

    localparam t_axis LHS0_3D [NUM_FACES_3D] = '{AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_X};
    localparam t_axis LHS1_3D [NUM_FACES_3D] = '{AXIS_Z, AXIS_Z, AXIS_Z, AXIS_Z, AXIS_Y, AXIS_Y};
    localparam t_axis LHS2_3D [NUM_FACES_3D] = '{AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Z, AXIS_Z};
    localparam t_axis LHS0_2D [NUM_FACES_2D] = '{AXIS_X, AXIS_Y, AXIS_X, AXIS_Y};
    localparam t_axis LHS1_2D [NUM_FACES_2D] = '{AXIS_Y, AXIS_X, AXIS_Y, AXIS_X};

    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    face_id;
        logic [FACE_W-1:0]  face_sel;
        logic [COORD_W-1:0] along_first;
        logic [COORD_W-1:0] along_second;
    } t_in_item;

    typedef struct packed {
        logic [FACE_W-1:0]  face_out;
        logic [COORD_W-1:0] coord_first;
        logic [COORD_W-1:0] coord_second;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [ID_W-1:0]    linear_id;
        logic               bad_input;
    } t_out_item;

    // Derived grid geometry; the user is to keep it steady while items are in flight, the block does not enforce this.
    typedef struct packed {
        logic                              three_d;
        logic [ORD_W-1:0]                  ord;
        logic [2:0][COARSE_BITS-1:0]       coarse;
        logic [2:0][FINE_W-1:0]            fine;
        logic [NUM_FACES_3D-1:0][ID_W-1:0] off;
        logic [ID_W-1:0]                   total;
    } t_geom;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic                   is_enc;
        logic                   bad;
        logic [FACE_W-1:0]      face;
        logic [ID_W-1:0]        val;
        logic [COORD_W-1:0]     mult;
        logic [FINE_W-1:0]      s0;
        logic [COARSE_BITS-1:0] div;
    } t_work;

    typedef struct packed {
        logic                   is_enc;
        logic                   bad;
        logic [FACE_W-1:0]      face;
        logic [ID_W-1:0]        val;
        logic [SIZE_W-1:0]      prod;
        logic [LOCAL_W-1:0]     y;
        logic [REM_W-1:0]       rem;
        logic [DIV_BITS-1:0]    quo;
        logic [COARSE_BITS-1:0] div;
    } t_bpipe;

    // Axis that runs along the first in-face coordinate.
    function automatic t_axis face_axis0(input logic three_d, input logic [FACE_W-1:0] face);
        t_axis a;
        a = AXIS_X;
        if (three_d) begin
            if (face < FACE_W'(NUM_FACES_3D)) a = LHS0_3D[face];
        end else if (face < FACE_W'(NUM_FACES_2D)) begin
            a = LHS0_2D[face[1:0]];
        end
        return a;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bfic_geom.sv */
// ----------------------------------------------------------------------------
// bfic_geom
// Configuration registers, register port and registered grid geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfic_geom (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bfic_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bfic_pkg::DATA_W-1:0]  pwdata,
    output logic      [bfic_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output bfic_pkg::t_geom                   o_geom,
    output logic                              o_settling
);
    localparam int CB = bfic_pkg::COARSE_BITS;
    localparam int FW = bfic_pkg::FINE_W;
    localparam int SW = bfic_pkg::SIZE_W;
    localparam int IW = bfic_pkg::ID_W;

    logic                      r_three_d;
    logic [2:0][CB-1:0]        r_coarse;
    logic [bfic_pkg::ORD_W-1:0] r_order;
    logic                      wr_en;
    logic [2:0]                reg_sel;

    logic                      r_g_three_d;
    logic [bfic_pkg::ORD_W-1:0] r_g_ord;
    logic [2:0][CB-1:0]        r_g_coarse;
    logic [2:0][FW-1:0]        r_g_fine;
    logic [SW-1:0]             r_size_a, r_size_b, r_size_c;
    logic [IW-1:0]             r_off1, r_off2, r_off3, r_off4, r_off5, r_total;
    logic [1:0]                r_settle;
    logic [bfic_pkg::ORD_W-1:0] ord_eff;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[bfic_pkg::ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d <= 1'b1;
            r_coarse  <= {3{CB'(1)}};
            r_order   <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                bfic_pkg::REG_THREE_D:  r_three_d   <= pwdata[0];
                bfic_pkg::REG_COARSE_X: r_coarse[0] <= pwdata[CB-1:0];
                bfic_pkg::REG_COARSE_Y: r_coarse[1] <= pwdata[CB-1:0];
                bfic_pkg::REG_COARSE_Z: r_coarse[2] <= pwdata[CB-1:0];
                bfic_pkg::REG_ORDER:    r_order     <= pwdata[bfic_pkg::ORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            bfic_pkg::REG_THREE_D:  prdata = bfic_pkg::DATA_W'(r_three_d);
            bfic_pkg::REG_COARSE_X: prdata = bfic_pkg::DATA_W'(r_coarse[0]);
            bfic_pkg::REG_COARSE_Y: prdata = bfic_pkg::DATA_W'(r_coarse[1]);
            bfic_pkg::REG_COARSE_Z: prdata = bfic_pkg::DATA_W'(r_coarse[2]);
            bfic_pkg::REG_ORDER:    prdata = bfic_pkg::DATA_W'(r_order);
            default: prdata = '0;
        endcase
    end

    assign ord_eff = (32'(r_order) > bfic_pkg::MAX_SUBDIVISION)
                   ? bfic_pkg::ORD_W'(bfic_pkg::MAX_SUBDIVISION) : r_order;

    // Three register stages: fine counts, face sizes, face offsets.
    always_ff @(posedge i_clk) begin
        r_g_three_d <= r_three_d;
        r_g_ord     <= ord_eff;
        for (int a = 0; a < 3; a++) begin
            r_g_coarse[a] <= (r_coarse[a] == '0) ? CB'(1) : r_coarse[a];
            r_g_fine[a]   <= FW'((r_coarse[a] == '0) ? CB'(1) : r_coarse[a]) << ord_eff;
        end
        r_size_a <= r_g_three_d ? SW'(r_g_fine[0] * r_g_fine[2]) : SW'(r_g_fine[0]);
        r_size_b <= r_g_three_d ? SW'(r_g_fine[1] * r_g_fine[2]) : SW'(r_g_fine[1]);
        r_size_c <= r_g_three_d ? SW'(r_g_fine[0] * r_g_fine[1]) : '0;
        r_off1   <= IW'(r_size_a);
        r_off2   <= IW'(r_size_a) + IW'(r_size_b);
        r_off3   <= IW'({r_size_a, 1'b0}) + IW'(r_size_b);
        r_off4   <= IW'({r_size_a, 1'b0}) + IW'({r_size_b, 1'b0});
        r_off5   <= IW'({r_size_a, 1'b0}) + IW'({r_size_b, 1'b0}) + IW'(r_size_c);
        r_total  <= IW'({r_size_a, 1'b0}) + IW'({r_size_b, 1'b0}) + IW'({r_size_c, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= 2'(bfic_pkg::SETTLE_CYCLES);
        end else if (wr_en) begin
            r_settle <= 2'(bfic_pkg::SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    assign o_settling = (r_settle != '0);

    always_comb begin
        o_geom.three_d = r_g_three_d;
        o_geom.ord     = r_g_ord;
        o_geom.coarse  = r_g_coarse;
        o_geom.fine    = r_g_fine;
        o_geom.off     = {r_off5, r_off4, r_off3, r_off2, r_off1, IW'(0)};
        o_geom.total   = r_total;
    end

endmodule
`default_nettype wire

/* rtl/core/bfic_front.sv */
// ----------------------------------------------------------------------------
// bfic_front
// Accepts items, finds the face of a decode id and the offset of an encode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfic_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  bfic_pkg::t_in_item      i_item,
    input  bfic_pkg::t_geom         i_geom,
    output logic                    o_valid,
    output bfic_pkg::t_work         o_work
);
    localparam int IW = bfic_pkg::ID_W;

    logic                          r_valid;
    bfic_pkg::t_work               r_work;
    bfic_pkg::t_work               n_work;
    logic [bfic_pkg::FACE_W-1:0]   dec_face;
    logic [bfic_pkg::FACE_W-1:0]   nfaces;
    bfic_pkg::t_axis               axis;

    always_comb begin
        dec_face = '0;
        for (int k = 1; k < bfic_pkg::NUM_FACES_3D; k++) begin
            dec_face = dec_face + bfic_pkg::FACE_W'(i_item.face_id >= i_geom.off[k]);
        end
        nfaces = i_geom.three_d ? bfic_pkg::FACE_W'(bfic_pkg::NUM_FACES_3D)
                                : bfic_pkg::FACE_W'(bfic_pkg::NUM_FACES_2D);
        n_work = '0;
        if (i_item.cmd == bfic_pkg::CMD_ENCODE) begin
            axis          = bfic_pkg::face_axis0(i_geom.three_d, i_item.face_sel);
            n_work.is_enc = 1'b1;
            n_work.bad    = (i_item.face_sel >= nfaces);
            n_work.face   = i_item.face_sel;
            n_work.val    = (i_item.face_sel < nfaces)
                          ? i_geom.off[i_item.face_sel] + IW'(i_item.along_first) : '0;
            n_work.mult   = i_geom.three_d ? i_item.along_second : '0;
        end else begin
            axis          = bfic_pkg::face_axis0(i_geom.three_d, dec_face);
            n_work.is_enc = 1'b0;
            n_work.bad    = (i_item.face_id >= i_geom.total);
            n_work.face   = dec_face;
            n_work.val    = IW'(bfic_pkg::LOCAL_W'(i_item.face_id - i_geom.off[dec_face]));
        end
        n_work.s0  = i_geom.fine[axis];
        n_work.div = i_geom.coarse[axis];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule
`default_nettype wire

/* rtl/core/bfic_fifo.sv */
// ----------------------------------------------------------------------------
// bfic_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bfic_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  bfic_pkg::t_work    i_work,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic               o_full,
    output bfic_pkg::t_work    o_work
);
    localparam int PTR_W = $clog2(bfic_pkg::QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    bfic_pkg::t_work   r_mem [bfic_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(bfic_pkg::QUEUE_DEPTH));
    assign o_work  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(bfic_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(bfic_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

/* rtl/core/bfic_back.sv */
// ----------------------------------------------------------------------------
// bfic_back
// Pipelined division, cell placement and id assembly; one result per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "boundary_face_index_codec_top_defines.svh"
module bfic_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  bfic_pkg::t_work        i_work,
    input  bfic_pkg::t_geom        i_geom,
    output logic                   o_done,
    output bfic_pkg::t_out_item    o_result
);
    localparam int NS = bfic_pkg::DIV_STAGES;
    localparam int FW = bfic_pkg::FINE_W;
    localparam int CW = bfic_pkg::COORD_W;
    localparam int RW = bfic_pkg::REM_W;

    logic [NS:0]        r_vld;
    bfic_pkg::t_bpipe   r_pipe [NS+1];
    bfic_pkg::t_bpipe   n_first;
    bfic_pkg::t_bpipe   n_step [NS];
    logic               r_done;
    bfic_pkg::t_out_item r_result;
    bfic_pkg::t_out_item n_result;

    // Entry stage: scale out the power-of-two part of the divisor, multiply encode stride.
    always_comb begin
        n_first        = '0;
        n_first.is_enc = i_work.is_enc;
        n_first.bad    = i_work.bad;
        n_first.face   = i_work.face;
        n_first.val    = i_work.val;
        n_first.div    = i_work.div;
        n_first.prod   = bfic_pkg::SIZE_W'(i_work.mult * i_work.s0);
        n_first.y      = bfic_pkg::LOCAL_W'(i_work.val >> i_geom.ord);
        n_first.rem    = RW'(n_first.y >> bfic_pkg::DIV_BITS);
    end

    // Restoring division, a few quotient bits per stage.
    for (genvar s = 0; s < NS; s++) begin : g_div
        always_comb begin
            n_step[s] = r_pipe[s];
            for (int j = 0; j < bfic_pkg::DIV_STEP; j++) begin
                n_step[s].rem = {n_step[s].rem[RW-2:0],
                                 r_pipe[s].y[bfic_pkg::DIV_BITS - 1 - (s * bfic_pkg::DIV_STEP + j)]};
                if (n_step[s].rem >= {1'b0, r_pipe[s].div}) begin
                    n_step[s].rem = n_step[s].rem - {1'b0, r_pipe[s].div};
                    n_step[s].quo = {n_step[s].quo[bfic_pkg::DIV_BITS-2:0], 1'b1};
                end else begin
                    n_step[s].quo = {n_step[s].quo[bfic_pkg::DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= n_first;
        for (int s = 0; s < NS; s++) begin
            r_pipe[s+1] <= n_step[s];
        end
    end

    // Final stage: rebuild the coordinates and place them on the bordering cell.
    always_comb begin
        logic [FW-1:0]      l0, l1, mask;
        logic [2:0][FW-1:0] pos;
        logic [FW-1:0]      last;
        logic [2:0]         f;
        bfic_pkg::t_bpipe   p;
        p    = r_pipe[NS];
        f    = p.face;
        mask = (FW'(1) << i_geom.ord) - FW'(1);
        l0   = (FW'(p.rem) << i_geom.ord) | (FW'(p.val) & mask);
        l1   = FW'(p.quo);
        pos  = '0;
        last = '0;
        if (f == 3'd1) last = i_geom.fine[bfic_pkg::AXIS_X] - FW'(1);
        if (f == 3'd2) last = i_geom.fine[bfic_pkg::AXIS_Y] - FW'(1);
        if (f == 3'd5) last = i_geom.fine[bfic_pkg::AXIS_Z] - FW'(1);
        if (i_geom.three_d) begin
            if (f < 3'(bfic_pkg::NUM_FACES_3D)) begin
                pos[bfic_pkg::LHS0_3D[f]] = l0;
                pos[bfic_pkg::LHS1_3D[f]] = l1;
                pos[bfic_pkg::LHS2_3D[f]] = last;
            end
        end else if (f < 3'(bfic_pkg::NUM_FACES_2D)) begin
            pos[bfic_pkg::LHS0_2D[f[1:0]]] = l0;
            pos[bfic_pkg::LHS1_2D[f[1:0]]] = last;
        end
        n_result = '0;
        if (p.bad) begin
            n_result.bad_input = 1'b1;
        end else if (p.is_enc) begin
            n_result.linear_id = p.val + bfic_pkg::ID_W'(p.prod);
        end else begin
            n_result.face_out     = f;
            n_result.coord_first  = CW'(l0);
            n_result.coord_second = CW'(l1);
            n_result.cell_x       = CW'(pos[bfic_pkg::AXIS_X]);
            n_result.cell_y       = CW'(pos[bfic_pkg::AXIS_Y]);
            n_result.cell_z       = CW'(pos[bfic_pkg::AXIS_Z]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `BFIC_ASSERT_NEXT(a_last_gives_done, i_clk, i_rst_n, r_vld[NS], o_done)
    `BFIC_ASSERT_NEXT(a_no_stray_done, i_clk, i_rst_n, !r_vld[NS], !o_done)
    `BFIC_ASSERT_IMPL(a_bad_clean, i_clk, i_rst_n, o_done && o_result.bad_input, o_result.linear_id == '0 && o_result.face_out == '0 && o_result.cell_x == '0)
    `BFIC_ASSERT_NEXT(a_enc_no_coords, i_clk, i_rst_n, r_vld[NS] && r_pipe[NS].is_enc, o_result.face_out == '0 && o_result.coord_first == '0)

endmodule
`default_nettype wire

/* rtl/core/boundary_face_index_codec_top.sv */
// ----------------------------------------------------------------------------
// boundary_face_index_codec_top
// Numbers the boundary face elements of a 2D or 3D Cartesian fine grid and
// converts between linear face ids and face, in-face and cell coordinates.
// ----------------------------------------------------------------------------
//  channel   | handshake                          | payload
//  ----------+------------------------------------+---------------------------
//  item in   | start, accepted when busy is low   | i_item (bfic_pkg::t_in_item)
//  result    | o_done strobe, one cycle, no stall | o_result (t_out_item)
//  registers | APB write psel/penable/pwrite      | paddr, pwdata, prdata
//
// One item is accepted every clock cycle while busy is low; each result
// passes the front register, the queue, the divider entry stage, the
// DIV_STAGES divider stages and the result register, the pipelined divider
// yielding three quotient bits per stage.
// After reset, and after every register write, busy stays high while the
// face sizes and offsets are recomputed.
// The receiver cannot stall; the front queue therefore never holds more than
// one item, and busy otherwise only reflects a full queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module boundary_face_index_codec_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  bfic_pkg::t_in_item               i_item,
    output logic                             o_done,
    output bfic_pkg::t_out_item              o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bfic_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bfic_pkg::DATA_W-1:0] pwdata,
    output logic      [bfic_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    bfic_pkg::t_geom geom;
    logic            settling;
    logic            take;
    logic            front_valid;
    bfic_pkg::t_work front_work;
    logic            q_valid;
    logic            q_full;
    bfic_pkg::t_work q_work;

    // An item is taken when start meets a free queue and settled geometry.
    assign busy = settling || q_full;
    assign take = start && !busy;

    // Configuration registers and the derived face sizes and offsets.
    bfic_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_geom     (geom),
        .o_settling (settling)
    );

    // Front: classifies the item, picks the face and the local index.
    bfic_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_item),
        .i_geom  (geom),
        .o_valid (front_valid),
        .o_work  (front_work)
    );

    // Queue decoupling the front from the back.
    bfic_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_work  (front_work),
        .i_pop   (q_valid),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_work  (q_work)
    );

    // Back: division by the face stride, cell placement and id assembly.
    bfic_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_work   (q_work),
        .i_geom   (geom),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
